// ===== rtl/hdp_pkg.sv =====
// Shared types and constants for the header directive parser.
package hdp_pkg;

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_NAME    = 6'b000010,
    PH_VSTART  = 6'b000100,
    PH_UNQ     = 6'b001000,
    PH_QLEAD   = 6'b010000,
    PH_QBODY   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // Output sequencer sub-steps within one burst.
  typedef enum logic [3:0] {
    SUB_BEGIN   = 4'b0001,
    SUB_HOLD    = 4'b0010,
    SUB_BYTE    = 4'b0100,
    SUB_SUMMARY = 4'b1000
  } sub_t;

  localparam logic [2:0] C_MANIFEST = 3'b001;
  localparam logic [2:0] C_MAXAGE   = 3'b010;
  localparam logic [2:0] C_MODE     = 3'b100;
  localparam logic [2:0] C_ALL      = 3'b111;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [30:0] AGE_MAX = 31'h7fffffff;

  function automatic logic [7:0] word_manifest(input logic [2:0] i);
    case (i)
      3'd0: word_manifest = 8'h6d;
      3'd1: word_manifest = 8'h61;
      3'd2: word_manifest = 8'h6e;
      3'd3: word_manifest = 8'h69;
      3'd4: word_manifest = 8'h66;
      3'd5: word_manifest = 8'h65;
      3'd6: word_manifest = 8'h73;
      default: word_manifest = 8'h74;
    endcase
  endfunction

  function automatic logic [7:0] word_maxage(input logic [2:0] i);
    case (i)
      3'd0: word_maxage = 8'h6d;
      3'd1: word_maxage = 8'h61;
      3'd2: word_maxage = 8'h78;
      3'd3: word_maxage = 8'h2d;
      3'd4: word_maxage = 8'h61;
      3'd5: word_maxage = 8'h67;
      default: word_maxage = 8'h65;
    endcase
  endfunction

  function automatic logic [7:0] word_mode(input logic [1:0] i);
    case (i)
      2'd0: word_mode = 8'h6d;
      2'd1: word_mode = 8'h6f;
      2'd2: word_mode = 8'h64;
      default: word_mode = 8'h65;
    endcase
  endfunction

  // What one parse step asks the output sequencer to send.
  typedef struct packed {
    logic        do_begin;
    logic        do_bytes;
    logic        do_summary;
    logic        target;
    logic [5:0]  hold_cnt;
    logic [63:0] hold_tabs;
    logic [7:0]  data_byte;
    logic        manifest_found;
    logic        mode_found;
    logic        age_valid;
    logic [30:0] age_seconds;
    logic        spaces_dropped;
  } step_t;

endpackage

// ===== rtl/hdp_parse.sv =====
// Parse state and per-byte next-state logic.
module hdp_parse import hdp_pkg::*; #(
  parameter int HOLD_CAP = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] header_byte,
  input  logic       end_of_header,
  output step_t      step
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [3:0]  npos_r, npos_nxt;
  logic        ntrail_r, ntrail_nxt;
  logic        qsingle_r, qsingle_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic [63:0] tabs_r, tabs_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        ns_minus_r, ns_minus_nxt, ns_sign_r, ns_sign_nxt;
  logic        ns_digit_r, ns_digit_nxt, ns_bad_r, ns_bad_nxt;
  logic        ff_man_r, ff_man_nxt, ff_mode_r, ff_mode_nxt;
  logic        ff_age_r, ff_age_nxt, ff_drop_r, ff_drop_nxt;
  logic [30:0] age_r, age_nxt;

  logic [7:0]  c;
  logic        is_ws;
  logic [35:0] acc_x10;
  logic [35:0] acc_sum;
  logic [7:0]  qch;

  assign c = header_byte;
  assign is_ws = (c == CH_SPACE) || (c == CH_TAB);
  assign acc_x10 = ({5'd0, acc_r} << 3) + ({5'd0, acc_r} << 1);
  assign acc_sum = acc_x10 + {28'd0, c - CH_0};
  assign qch = qsingle_r ? CH_SQ : CH_DQ;

  always_comb begin
    logic [2:0] m;
    logic       strm;
    logic       v_done;
    logic       v_char;
    logic       v_ws;
    logic       n_done;
    logic       n_char;
    phase_t     ph_after;
    m = 3'd0;
    strm = 1'b0;
    v_done = 1'b0;
    v_char = 1'b0;
    v_ws = 1'b0;
    n_done = 1'b0;
    n_char = 1'b0;
    phase_nxt = phase_r;
    cand_nxt = cand_r;
    npos_nxt = npos_r;
    ntrail_nxt = ntrail_r;
    qsingle_nxt = qsingle_r;
    pend_nxt = pend_r;
    tabs_nxt = tabs_r;
    acc_nxt = acc_r;
    ns_minus_nxt = ns_minus_r;
    ns_sign_nxt = ns_sign_r;
    ns_digit_nxt = ns_digit_r;
    ns_bad_nxt = ns_bad_r;
    ff_man_nxt = ff_man_r;
    ff_mode_nxt = ff_mode_r;
    ff_age_nxt = ff_age_r;
    ff_drop_nxt = ff_drop_r;
    age_nxt = age_r;
    step = '0;

    case (phase_r)
      PH_BETWEEN: begin
        if (!(is_ws || c == CH_COMMA)) begin
          cand_nxt = C_ALL;
          npos_nxt = 4'd0;
          ntrail_nxt = 1'b0;
          if (c == CH_EQ) begin
            cand_nxt = 3'd0;
            n_done = 1'b1;
          end else begin
            phase_nxt = PH_NAME;
            n_char = 1'b1;
          end
        end
      end
      PH_NAME: begin
        if (c == CH_EQ) n_done = 1'b1;
        else if (c == CH_COMMA) phase_nxt = PH_BETWEEN;
        else if (is_ws) ntrail_nxt = 1'b1;
        else n_char = 1'b1;
      end
      PH_VSTART: begin
        if (!is_ws) begin
          if (c == CH_DQ || c == CH_SQ) begin
            qsingle_nxt = (c == CH_SQ);
            phase_nxt = PH_QLEAD;
          end else if (c == CH_COMMA) begin
            v_done = 1'b1;
          end else begin
            phase_nxt = PH_UNQ;
            v_char = 1'b1;
          end
        end
      end
      PH_UNQ: begin
        if (c == CH_COMMA) v_done = 1'b1;
        else if (is_ws) v_ws = 1'b1;
        else v_char = 1'b1;
      end
      PH_QLEAD, PH_QBODY: begin
        if (c == qch) v_done = 1'b1;
        else if (is_ws) v_ws = (phase_r == PH_QBODY);
        else begin
          phase_nxt = PH_QBODY;
          v_char = 1'b1;
        end
      end
      default: phase_nxt = PH_BETWEEN;
    endcase

    if (n_char) begin
      if (ntrail_nxt) begin
        cand_nxt = 3'd0;
      end else begin
        if (npos_nxt >= 4'd8 || word_manifest(npos_nxt[2:0]) != c)
          cand_nxt = cand_nxt & ~C_MANIFEST;
        if (npos_nxt >= 4'd7 || word_maxage(npos_nxt[2:0]) != c)
          cand_nxt = cand_nxt & ~C_MAXAGE;
        if (npos_nxt >= 4'd4 || word_mode(npos_nxt[1:0]) != c)
          cand_nxt = cand_nxt & ~C_MODE;
      end
      if (npos_nxt != 4'd15) npos_nxt = npos_nxt + 4'd1;
    end

    if (n_done) begin
      if (cand_nxt[0] && npos_nxt == 4'd8) m = C_MANIFEST;
      else if (cand_nxt[1] && npos_nxt == 4'd7) m = C_MAXAGE;
      else if (cand_nxt[2] && npos_nxt == 4'd4) m = C_MODE;
      cand_nxt = m;
      pend_nxt = '0;
      tabs_nxt = '0;
      acc_nxt = '0;
      {ns_minus_nxt, ns_sign_nxt, ns_digit_nxt, ns_bad_nxt} = 4'd0;
      if (m == C_MANIFEST) ff_man_nxt = 1'b1;
      if (m == C_MODE) ff_mode_nxt = 1'b1;
      step.do_begin = (m == C_MANIFEST) || (m == C_MODE);
      step.target = (m == C_MODE);
      phase_nxt = PH_VSTART;
    end

    strm = (cand_r == C_MANIFEST) || (cand_r == C_MODE);

    if (v_ws) begin
      if (strm) begin
        if (pend_r >= 6'(HOLD_CAP)) begin
          ff_drop_nxt = 1'b1;
        end else begin
          if (c == CH_TAB) tabs_nxt[pend_r] = 1'b1;
          pend_nxt = pend_r + 6'd1;
        end
      end else if (cand_r == C_MAXAGE) begin
        pend_nxt = 6'd1;
      end
    end

    if (v_char) begin
      if (strm) begin
        step.do_bytes = 1'b1;
        step.target = (cand_r == C_MODE);
        step.hold_cnt = pend_r;
        step.hold_tabs = tabs_r;
        step.data_byte = c;
        pend_nxt = '0;
        tabs_nxt = '0;
      end else if (cand_r == C_MAXAGE) begin
        if (pend_r != 6'd0) begin
          ns_bad_nxt = 1'b1;
        end else if (c >= CH_0 && c <= CH_9) begin
          if (acc_sum > {5'd0, AGE_MAX}) ns_bad_nxt = 1'b1;
          else acc_nxt = acc_sum[30:0];
          ns_digit_nxt = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          if (ns_sign_r || ns_digit_r) ns_bad_nxt = 1'b1;
          else begin
            ns_sign_nxt = 1'b1;
            if (c == CH_MINUS) ns_minus_nxt = 1'b1;
          end
        end else begin
          ns_bad_nxt = 1'b1;
        end
      end
    end

    // The end flag closes any open value after this byte's own update.
    ph_after = phase_nxt;
    if (end_of_header && (ph_after == PH_VSTART || ph_after == PH_UNQ ||
        ph_after == PH_QLEAD || ph_after == PH_QBODY))
      v_done = 1'b1;

    if (v_done) begin
      if (cand_nxt == C_MAXAGE && !ns_bad_nxt && ns_digit_nxt &&
          (!ns_minus_nxt || acc_nxt == 31'd0)) begin
        age_nxt = acc_nxt;
        ff_age_nxt = 1'b1;
      end
      pend_nxt = '0;
      tabs_nxt = '0;
      acc_nxt = '0;
      {ns_minus_nxt, ns_sign_nxt, ns_digit_nxt, ns_bad_nxt} = 4'd0;
      phase_nxt = PH_BETWEEN;
    end

    if (end_of_header) begin
      step.do_summary = 1'b1;
      step.manifest_found = ff_man_nxt;
      step.mode_found = ff_mode_nxt;
      step.age_valid = ff_age_nxt;
      step.age_seconds = age_nxt;
      step.spaces_dropped = ff_drop_nxt;
      phase_nxt = PH_BETWEEN;
      cand_nxt = C_ALL;
      npos_nxt = '0;
      ntrail_nxt = 1'b0;
      qsingle_nxt = 1'b0;
      pend_nxt = '0;
      tabs_nxt = '0;
      acc_nxt = '0;
      {ns_minus_nxt, ns_sign_nxt, ns_digit_nxt, ns_bad_nxt} = 4'd0;
      {ff_man_nxt, ff_mode_nxt, ff_age_nxt, ff_drop_nxt} = 4'd0;
      age_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BETWEEN;
      cand_r <= C_ALL;
      npos_r <= '0;
      ntrail_r <= 1'b0;
      qsingle_r <= 1'b0;
      pend_r <= '0;
      tabs_r <= '0;
      acc_r <= '0;
      {ns_minus_r, ns_sign_r, ns_digit_r, ns_bad_r} <= 4'd0;
      {ff_man_r, ff_mode_r, ff_age_r, ff_drop_r} <= 4'd0;
      age_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cand_r <= cand_nxt;
      npos_r <= npos_nxt;
      ntrail_r <= ntrail_nxt;
      qsingle_r <= qsingle_nxt;
      pend_r <= pend_nxt;
      tabs_r <= tabs_nxt;
      acc_r <= acc_nxt;
      {ns_minus_r, ns_sign_r, ns_digit_r, ns_bad_r} <=
        {ns_minus_nxt, ns_sign_nxt, ns_digit_nxt, ns_bad_nxt};
      {ff_man_r, ff_mode_r, ff_age_r, ff_drop_r} <=
        {ff_man_nxt, ff_mode_nxt, ff_age_nxt, ff_drop_nxt};
      age_r <= age_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 6'(HOLD_CAP) || cand_r == C_MAXAGE) else $error("hold count over cap");
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && end_of_header |=> phase_r == PH_BETWEEN && cand_r == C_ALL)
    else $error("state not reset after header end");
  a_stream_alone: assert property (@(posedge clk) disable iff (!rst_n)
    !(step.do_begin && step.do_bytes)) else $error("begin and bytes in one step");
`endif

endmodule

// ===== rtl/hdp_emit.sv =====
// Output sequencer: plays one parse step out as a burst of results.
module hdp_emit import hdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  step_t       step,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_target,
  output logic [7:0]  out_data_byte,
  output logic        out_manifest_found,
  output logic        out_mode_found,
  output logic        out_age_valid,
  output logic [30:0] out_age_seconds,
  output logic        out_spaces_dropped,
  output logic        out_last
);

  step_t      job_r;
  logic       act_r;
  logic [5:0] idx_r;
  // Sub-step: begin marker, held whitespace, value byte or summary.
  sub_t       sub_r;
  sub_t       sub_first;
  sub_t       sub_next;
  logic       final_one;
  logic       adv;

  always_comb begin
    if (step.do_begin) sub_first = SUB_BEGIN;
    else if (step.do_bytes && step.hold_cnt != 6'd0) sub_first = SUB_HOLD;
    else if (step.do_bytes) sub_first = SUB_BYTE;
    else sub_first = SUB_SUMMARY;
  end

  always_comb begin
    sub_next = sub_r;
    final_one = 1'b0;
    case (sub_r)
      SUB_BEGIN: begin
        if (job_r.do_summary) sub_next = SUB_SUMMARY;
        else final_one = 1'b1;
      end
      SUB_HOLD: begin
        if (idx_r + 6'd1 == job_r.hold_cnt) sub_next = SUB_BYTE;
      end
      SUB_BYTE: begin
        if (job_r.do_summary) sub_next = SUB_SUMMARY;
        else final_one = 1'b1;
      end
      default: final_one = 1'b1;
    endcase
  end

  assign adv = act_r && out_ready;
  assign busy = act_r && !(out_ready && final_one);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      sub_r <= SUB_BEGIN;
      idx_r <= '0;
    end else if (load) begin
      act_r <= step.do_begin || step.do_bytes || step.do_summary;
      sub_r <= sub_first;
      idx_r <= '0;
    end else if (adv) begin
      if (final_one) act_r <= 1'b0;
      sub_r <= sub_next;
      idx_r <= (sub_r == SUB_HOLD) ? idx_r + 6'd1 : idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= step;
  end

  assign out_valid = act_r;
  assign out_last = final_one;
  always_comb begin
    out_kind = KIND_SUMMARY;
    out_target = 1'b0;
    out_data_byte = 8'd0;
    case (sub_r)
      SUB_BEGIN: begin
        out_kind = KIND_BEGIN;
        out_target = job_r.target;
      end
      SUB_HOLD: begin
        out_kind = KIND_BYTE;
        out_target = job_r.target;
        out_data_byte = job_r.hold_tabs[idx_r] ? CH_TAB : CH_SPACE;
      end
      SUB_BYTE: begin
        out_kind = KIND_BYTE;
        out_target = job_r.target;
        out_data_byte = job_r.data_byte;
      end
      default: out_kind = KIND_SUMMARY;
    endcase
    out_manifest_found = (sub_r == SUB_SUMMARY) && job_r.manifest_found;
    out_mode_found = (sub_r == SUB_SUMMARY) && job_r.mode_found;
    out_age_valid = (sub_r == SUB_SUMMARY) && job_r.age_valid;
    out_age_seconds = (sub_r == SUB_SUMMARY) ? job_r.age_seconds : 31'd0;
    out_spaces_dropped = (sub_r == SUB_SUMMARY) && job_r.spaces_dropped;
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && sub_r == SUB_HOLD |-> idx_r < job_r.hold_cnt)
    else $error("hold index out of range");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy) else $error("load while burst pending");
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && sub_r == SUB_SUMMARY |-> final_one) else $error("summary not final");
`endif

endmodule

// ===== rtl/header_directive_parser.sv =====
// Top level of the header directive parser.
//
// Usage: header bytes enter on the in_ channel (valid/ready), one byte per
// request, with in_end_of_header on the final byte. Each accepted byte
// causes zero or more results on the out_ channel: a begin marker when a
// manifest or mode value starts, value bytes (held inner whitespace plus the
// byte that releases it), and a summary after the final byte. out_last marks
// the final result of each byte's burst.
// The first result of a byte appears in the cycle after its acceptance.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_ready is high; the output sequencer sends one result per cycle
// while out_ready is high, keeping a byte's N results in the output register.
// in_ready stays high while the current burst is finishing this cycle, so
// bursts follow each other without a gap. When the receiver stalls, the
// burst holds and in_ready falls until its last result is taken.
// Reset (rst_n low, synchronous) returns the parse state to between
// directives, clears all flags and drops any pending result.
module header_directive_parser import hdp_pkg::*; #(
  parameter int PENDING_LIMIT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_header_byte,
  input  logic        in_end_of_header,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_target,
  output logic [7:0]  out_data_byte,
  output logic        out_manifest_found,
  output logic        out_mode_found,
  output logic        out_age_valid,
  output logic [30:0] out_age_seconds,
  output logic        out_spaces_dropped,
  output logic        out_last
);

  localparam int HOLD_CAP = (PENDING_LIMIT < 33) ? PENDING_LIMIT : 33;

  step_t step;
  logic  busy;
  logic  accept;

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;

  hdp_parse #(.HOLD_CAP(HOLD_CAP)) u_parse (
    .clk(clk), .rst_n(rst_n), .step_en(accept),
    .header_byte(in_header_byte), .end_of_header(in_end_of_header),
    .step(step)
  );

  hdp_emit u_emit (
    .clk(clk), .rst_n(rst_n), .load(accept), .step(step), .busy(busy),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_target(out_target), .out_data_byte(out_data_byte),
    .out_manifest_found(out_manifest_found), .out_mode_found(out_mode_found),
    .out_age_valid(out_age_valid), .out_age_seconds(out_age_seconds),
    .out_spaces_dropped(out_spaces_dropped), .out_last(out_last)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped under stall");
  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("accepted during stall");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && out_valid && out_ready && out_last |=> !out_valid)
    else $error("burst continued past last");
`endif

endmodule
